[rtl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/imucf_pkg.sv]
// Package with constants, types and tables for the complementary filter.
package imucf_pkg;
  localparam int unsigned GainOne = 65536;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned QueueDepthDefault = 2;
  localparam logic signed [35:0] PiQ24 = 36'sd52707179;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic        [23:0] dt;
    logic        [31:0] index;
  } sample_t;

  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] r;
    begin
      case (i)
        5'd0: r = 24'd13176795;
        5'd1: r = 24'd7778716;
        5'd2: r = 24'd4110060;
        5'd3: r = 24'd2086331;
        5'd4: r = 24'd1047214;
        5'd5: r = 24'd524117;
        5'd6: r = 24'd262123;
        5'd7: r = 24'd131069;
        default: r = 24'd1 << (5'd24 - i);
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    end
  endfunction
endpackage

[rtl/imucf_queue.sv]
// Small queue of accepted samples between the input ports and the back part.
module imucf_queue import imucf_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  sample_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output sample_t rd_data,
  output logic    empty
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  sample_t mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(Depth));
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en && !full)
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en && !empty)
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule

[rtl/imucf_back.sv]
// Back part: integration, square root, two CORDIC atan2 runs and the blend.
module imucf_back import imucf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [16:0]        gain,
  input  logic               q_empty,
  input  sample_t            q_data,
  output logic               q_pop,
  output logic               res_ready,
  input  logic               res_take,
  output logic               out_valid,
  output logic signed [31:0] roll_angle,
  output logic signed [31:0] pitch_angle,
  output logic signed [31:0] yaw_angle,
  output logic signed [31:0] held_rate_x,
  output logic signed [31:0] held_rate_y,
  output logic signed [31:0] held_rate_z,
  output logic [31:0]        held_count
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_INT, S_SQRT, S_ATAN_SET, S_ATAN, S_ATAN_END, S_BLEND, S_OUT
  } state_t;

  state_t state;
  sample_t cur;
  logic signed [63:0] prod;
  logic [1:0] mul_sel;
  logic signed [31:0] roll_reg, pitch_reg, yaw_reg;
  logic [63:0] sq_n, sq_res, sq_bit;
  logic [63:0] mag2;
  logic [1:0] sq_phase;
  // CORDIC
  logic signed [58:0] cx, cy;
  logic signed [35:0] cz;
  logic [4:0] ci;
  logic which;
  logic signed [31:0] acc_roll, acc_pitch;
  logic [16:0] g;
  logic [2:0] bl_step;
  logic signed [63:0] bl_acc;

  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [35:0] z_round;
  logic [63:0] sq_try;

  always_comb begin
    case (mul_sel)
      2'd0: mul_a = cur.rate_x;
      2'd1: mul_a = cur.rate_y;
      default: mul_a = cur.rate_z;
    endcase
    mul_b = $signed({1'b0, cur.dt});
  end

  assign sq_try = sq_res + sq_bit;
  assign z_round = (cz + 36'sd128) >>> 8;

  assign res_ready = (state == S_OUT);
  assign q_pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      roll_reg <= '0;
      pitch_reg <= '0;
      yaw_reg <= '0;
      held_rate_x <= '0;
      held_rate_y <= '0;
      held_rate_z <= '0;
      held_count <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_data;
            mul_sel <= 2'd0;
            g <= (gain > 17'(GainOne)) ? 17'(GainOne) : gain;
            state <= q_data.ok ? S_MUL : S_OUT;
            if (!q_data.ok) out_valid <= 1'b0;
          end
        end
        S_MUL: begin
          prod <= 64'(mul_a) * 64'(mul_b);
          state <= S_INT;
        end
        S_INT: begin
          case (mul_sel)
            2'd0: roll_reg <= sat32(64'(roll_reg) + ((prod + 64'sd8388608) >>> 24));
            2'd1: pitch_reg <= sat32(64'(pitch_reg) + ((prod + 64'sd8388608) >>> 24));
            default: yaw_reg <= sat32(64'(yaw_reg) + ((prod + 64'sd8388608) >>> 24));
          endcase
          if (mul_sel == 2'd2) begin
            sq_phase <= 2'd0;
            state <= S_SQRT;
          end else begin
            mul_sel <= mul_sel + 2'd1;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          case (sq_phase)
            2'd0: begin
              prod <= 64'(cur.accel_y) * 64'(cur.accel_y);
              sq_phase <= 2'd1;
            end
            2'd1: begin
              mag2 <= prod;
              prod <= 64'(cur.accel_z) * 64'(cur.accel_z);
              sq_phase <= 2'd2;
            end
            2'd2: begin
              sq_n <= mag2 + prod;
              sq_res <= '0;
              sq_bit <= 64'd1 << 62;
              sq_phase <= 2'd3;
            end
            default: begin
              if (sq_bit == '0) begin
                which <= 1'b0;
                state <= S_ATAN_SET;
              end else begin
                if (sq_n >= sq_try) begin
                  sq_n <= sq_n - sq_try;
                  sq_res <= (sq_res >> 1) + sq_bit;
                end else begin
                  sq_res <= sq_res >> 1;
                end
                sq_bit <= sq_bit >> 2;
              end
            end
          endcase
        end
        S_ATAN_SET: begin
          // Roll uses (ay, az); pitch uses (-ax, mag). Operands go to Q.24 scaling.
          logic signed [34:0] y0, x0;
          y0 = which ? -35'(cur.accel_x) : 35'(cur.accel_y);
          x0 = which ? $signed({3'd0, sq_res[31:0]}) : 35'(cur.accel_z);
          ci <= '0;
          if (y0 == 0) begin
            cz <= (x0 < 0) ? (PiQ24 <<< 0) : '0;
            cx <= '0;
            cy <= '0;
            state <= S_ATAN_END;
          end else begin
            if (x0 < 0) begin
              cz <= (y0 > 0) ? PiQ24 : -PiQ24;
              cx <= 59'(-x0) <<< 24;
              cy <= 59'(-y0) <<< 24;
            end else begin
              cz <= '0;
              cx <= 59'(x0) <<< 24;
              cy <= 59'(y0) <<< 24;
            end
            state <= S_ATAN;
          end
        end
        S_ATAN: begin
          if (cy > 0) begin
            cx <= cx + (cy >>> ci);
            cy <= cy - (cx >>> ci);
            cz <= cz + 36'(atan_entry(ci));
          end else begin
            cx <= cx - (cy >>> ci);
            cy <= cy + (cx >>> ci);
            cz <= cz - 36'(atan_entry(ci));
          end
          if (ci == 5'(CordicSteps - 1)) state <= S_ATAN_END;
          ci <= ci + 5'd1;
        end
        S_ATAN_END: begin
          if (!which) begin
            acc_roll <= sat32(64'(z_round));
            which <= 1'b1;
            state <= S_ATAN_SET;
          end else begin
            acc_pitch <= sat32(64'(z_round));
            bl_step <= '0;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          case (bl_step)
            3'd0: bl_acc <= 64'($signed({1'b0, 17'(GainOne) - g})) * 64'(roll_reg);
            3'd1: bl_acc <= bl_acc + 64'($signed({1'b0, g})) * 64'(acc_roll);
            3'd2: roll_reg <= sat32((bl_acc + 64'sd32768) >>> 16);
            3'd3: bl_acc <= 64'($signed({1'b0, 17'(GainOne) - g})) * 64'(pitch_reg);
            3'd4: bl_acc <= bl_acc + 64'($signed({1'b0, g})) * 64'(acc_pitch);
            default: begin
              pitch_reg <= sat32((bl_acc + 64'sd32768) >>> 16);
              held_rate_x <= cur.rate_x;
              held_rate_y <= cur.rate_y;
              held_rate_z <= cur.rate_z;
              held_count <= cur.index;
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          endcase
          bl_step <= bl_step + 3'd1;
        end
        S_OUT: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign roll_angle = roll_reg;
  assign pitch_angle = pitch_reg;
  assign yaw_angle = yaw_reg;
endmodule

[rtl/imu_complementary_filter.sv]
// Top level of the complementary-filter attitude estimator.
// Usage: samples are pushed into the input queue with push while full is low.
// Each accepted word yields exactly one result word, in order. A result is on
// the result ports while empty is low and leaves with pop.
// correction_gain is written with gain_we and gain_wdata while idle; values
// above 65536 act as 65536.
// An invalid sample shows its result in the cycle after the queue hands it to
// an idle back part. A valid sample passes through integration, the 32-step
// square root, two 24-step CORDIC atan2 runs (the iterations are skipped when
// the first operand is zero) and the blend, in that order.
// The back part handles one sample at a time: it takes the next sample only
// after the result of the last one has been popped.
// The input queue holds two samples by default, so pushes continue while the
// back part works. The result is held until popped; while pop stays low, the
// back part stops and the input queue fills, then full rises.
// Reset clears the attitude, held rates, count, gain and both queue sides.
module imu_complementary_filter import imucf_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               sample_ok,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic [23:0]        delta_time,
  input  logic [31:0]        sample_index,
  input  logic               gain_we,
  input  logic [16:0]        gain_wdata,
  output logic               empty,
  input  logic               pop,
  output logic               out_valid,
  output logic signed [31:0] roll_angle,
  output logic signed [31:0] pitch_angle,
  output logic signed [31:0] yaw_angle,
  output logic signed [31:0] held_rate_x,
  output logic signed [31:0] held_rate_y,
  output logic signed [31:0] held_rate_z,
  output logic [31:0]        held_count
);
  logic [16:0] correction_gain;
  sample_t in_word, q_data;
  logic q_empty, q_pop, res_ready;

  always_ff @(posedge clk) begin
    if (rst) correction_gain <= '0;
    else if (gain_we) correction_gain <= gain_wdata;
  end

  assign in_word = '{ok: sample_ok, rate_x: rate_x, rate_y: rate_y, rate_z: rate_z,
                     accel_x: accel_x, accel_y: accel_y, accel_z: accel_z,
                     dt: delta_time, index: sample_index};

  imucf_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_en(push), .wr_data(in_word), .full,
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  imucf_back u_back (
    .clk, .rst, .gain(correction_gain), .q_empty, .q_data, .q_pop,
    .res_ready, .res_take(pop), .out_valid, .roll_angle, .pitch_angle,
    .yaw_angle, .held_rate_x, .held_rate_y, .held_rate_z, .held_count
  );

  assign empty = !res_ready;
endmodule

[rtl/imucf_checker.sv]
// Port-level checker for the complementary filter, bound to the top level.
`include "assert_macros.svh"
module imucf_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        out_valid,
  input logic [31:0] held_count,
  input logic [31:0] yaw_angle
);
  `CHK_NEXT(a_rst_empty, clk, 1'b0, rst, empty)
  `CHK_NEXT(a_hold_word, clk, rst, !empty && !pop, !empty && $stable(held_count))
  `CHK_NEXT(a_yaw_stable, clk, rst, !empty && !pop, $stable(yaw_angle))
  `CHK_NEXT(a_valid_stable, clk, rst, !empty && !pop, $stable(out_valid))
  `CHK_NEXT(a_pop_leaves, clk, rst, !empty && pop, empty)
endmodule

bind imu_complementary_filter imucf_checker u_checker (
  .clk, .rst, .empty, .pop, .out_valid, .held_count, .yaw_angle
);
